/* rtl/core/boris_particle_push_unit_assert.svh */
// Assertion macros shared by the particle push RTL.
// Each macro checks on the rising edge of clk and is held off while rst_n is low.
`ifndef BORIS_PARTICLE_PUSH_UNIT_ASSERT_SVH
`define BORIS_PARTICLE_PUSH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BPP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpp: same-cycle check failed");
`define BPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpp: next-cycle check failed");
`else
`define BPP_ASSERT_IMP(lbl, ante, cons)
`define BPP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/bpp_pkg.sv */
package bpp_pkg;

  localparam int WORD_W = 32;
  localparam int DEN_W = 34;
  localparam int QUO_W = 33;
  localparam int CFG_IDX_W = 2;
  localparam int FRONT_STAGES = 7;
  localparam int BACK_STAGES = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd1;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [2:0] vec3_t;
  typedef logic signed [2*WORD_W-1:0] prod_t;
  typedef prod_t [2:0] prod3_t;

  typedef struct packed {
    vec3_t vp;
    vec3_t u;
    vec3_t r;
    vec3_t pos;
  } carry_t;

  localparam word_t WORD_MAX = 32'h7fff_ffff;
  localparam word_t WORD_MIN = 32'h8000_0000;
  localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
  localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;

  function automatic int nx(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  function automatic int pv(input int i);
    return (i == 0) ? 2 : i - 1;
  endfunction

  function automatic word_t sat_wide(input logic signed [65:0] v);
    if (v > WIDE_MAX) return WORD_MAX;
    else if (v < WIDE_MIN) return WORD_MIN;
    else return v[WORD_W-1:0];
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    return sat_wide(66'($signed(a)) + 66'($signed(b)));
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    return sat_wide(66'($signed(a)) - 66'($signed(b)));
  endfunction

  function automatic prod_t smul(input word_t a, input word_t b);
    prod_t r;
    r = $signed(a) * $signed(b);
    return r;
  endfunction

  // round half up, drop the fraction, clamp to one word
  function automatic word_t fin(input prod_t p, input int frac);
    logic signed [65:0] s;
    s = 66'(p) + (66'sd1 <<< (frac - 1));
    s = s >>> frac;
    return sat_wide(s);
  endfunction

  function automatic word_t abs_word(input word_t v);
    return v[WORD_W-1] ? word_t'(-v) : v;
  endfunction

endpackage

/* rtl/core/bpp_front.sv */
`include "boris_particle_push_unit_assert.svh"

module bpp_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  bpp_pkg::vec3_t                            in_pos,
  input  bpp_pkg::vec3_t                            in_vel,
  input  bpp_pkg::vec3_t                            in_flow,
  input  bpp_pkg::vec3_t                            in_mag,
  input  bpp_pkg::word_t                            field_scale,
  output logic                                      out_valid,
  output bpp_pkg::carry_t                           out_carry,
  output logic [2:0][FRAC_BITS+bpp_pkg::QUO_W-1:0]  out_num,
  output logic [2:0]                                out_neg,
  output logic [bpp_pkg::DEN_W-1:0]                 out_den
);
  import bpp_pkg::*;

  localparam int NUM_W = FRAC_BITS + QUO_W;
  localparam logic [DEN_W-1:0] ONE = DEN_W'(1) << FRAC_BITS;

  logic [FRONT_STAGES:1] v_r;

  prod3_t pca1_r, pcb1_r, pkm1_r;
  vec3_t  pos1_r, vel1_r;
  vec3_t  ub2_r, t2_r, pos2_r, vel2_r;
  prod3_t pku3_r, ptt3_r;
  vec3_t  t3_r, pos3_r, vel3_r;
  vec3_t  r4_r, t4_r, pos4_r, vel4_r;
  logic [DEN_W-1:0] den4_r;
  vec3_t  u5_r, r5_r, t5_r, pos5_r;
  logic [2:0][NUM_W-1:0] num5_r;
  logic [2:0] neg5_r;
  logic [DEN_W-1:0] den5_r;
  prod3_t uta6_r, utb6_r;
  vec3_t  u6_r, r6_r, pos6_r;
  logic [2:0][NUM_W-1:0] num6_r;
  logic [2:0] neg6_r;
  logic [DEN_W-1:0] den6_r;
  carry_t carry7_r;
  logic [2:0][NUM_W-1:0] num7_r;
  logic [2:0] neg7_r;
  logic [DEN_W-1:0] den7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[FRONT_STAGES-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      // U x B products and k*B
      pca1_r[i] <= smul(in_flow[nx(i)], in_mag[pv(i)]);
      pcb1_r[i] <= smul(in_flow[pv(i)], in_mag[nx(i)]);
      pkm1_r[i] <= smul(field_scale, in_mag[i]);

      ub2_r[i] <= sat_sub(fin(pca1_r[i], FRAC_BITS), fin(pcb1_r[i], FRAC_BITS));
      t2_r[i]  <= fin(pkm1_r[i], FRAC_BITS);

      pku3_r[i] <= smul(field_scale, ub2_r[i]);
      ptt3_r[i] <= smul(t2_r[i], t2_r[i]);

      r4_r[i] <= sat_sub('0, fin(pku3_r[i], FRAC_BITS));

      u5_r[i]   <= sat_add(vel4_r[i], r4_r[i]);
      // numerator carries half the divisor for round-to-nearest
      num5_r[i] <= {abs_word(t4_r[i]), {(FRAC_BITS+1){1'b0}}} + NUM_W'(den4_r >> 1);
      neg5_r[i] <= t4_r[i][WORD_W-1];

      uta6_r[i] <= smul(u5_r[nx(i)], t5_r[pv(i)]);
      utb6_r[i] <= smul(u5_r[pv(i)], t5_r[nx(i)]);

      carry7_r.vp[i] <= sat_add(u6_r[i],
                                sat_sub(fin(uta6_r[i], FRAC_BITS), fin(utb6_r[i], FRAC_BITS)));
    end
    pos1_r <= in_pos;
    vel1_r <= in_vel;
    pos2_r <= pos1_r;
    vel2_r <= vel1_r;
    t3_r   <= t2_r;
    pos3_r <= pos2_r;
    vel3_r <= vel2_r;
    den4_r <= ONE + DEN_W'(fin(ptt3_r[0], FRAC_BITS)) + DEN_W'(fin(ptt3_r[1], FRAC_BITS))
              + DEN_W'(fin(ptt3_r[2], FRAC_BITS));
    t4_r   <= t3_r;
    pos4_r <= pos3_r;
    vel4_r <= vel3_r;
    r5_r   <= r4_r;
    t5_r   <= t4_r;
    pos5_r <= pos4_r;
    den5_r <= den4_r;
    u6_r   <= u5_r;
    r6_r   <= r5_r;
    pos6_r <= pos5_r;
    num6_r <= num5_r;
    neg6_r <= neg5_r;
    den6_r <= den5_r;
    carry7_r.u   <= u6_r;
    carry7_r.r   <= r6_r;
    carry7_r.pos <= pos6_r;
    num7_r <= num6_r;
    neg7_r <= neg6_r;
    den7_r <= den6_r;
  end

  assign out_valid = v_r[FRONT_STAGES];
  assign out_carry = carry7_r;
  assign out_num   = num7_r;
  assign out_neg   = neg7_r;
  assign out_den   = den7_r;

  `BPP_ASSERT_IMP(a_den_floor, v_r[4], den4_r >= ONE)

endmodule

/* rtl/core/bpp_divider.sv */
`include "boris_particle_push_unit_assert.svh"

module bpp_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  bpp_pkg::carry_t                           in_carry,
  input  logic [2:0][FRAC_BITS+bpp_pkg::QUO_W-1:0]  in_num,
  input  logic [2:0]                                in_neg,
  input  logic [bpp_pkg::DEN_W-1:0]                 in_den,
  output logic                                      out_valid,
  output bpp_pkg::vec3_t                            out_quot,
  output bpp_pkg::carry_t                           out_carry
);
  import bpp_pkg::*;

  localparam int NUM_W = FRAC_BITS + QUO_W;
  localparam logic [QUO_W-1:0] QPOS_MAX = QUO_W'(64'h7fff_ffff);
  localparam logic [QUO_W-1:0] QNEG_MAX = QUO_W'(64'h8000_0000);

  logic [QUO_W-1:0] v_r;
  logic [2:0][DEN_W-1:0] rem_r [QUO_W];
  logic [2:0][QUO_W-1:0] nlo_r [QUO_W];
  logic [2:0][QUO_W-1:0] q_r [QUO_W];
  logic [2:0] neg_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  carry_t carry_r [QUO_W];

  logic [2:0][DEN_W-1:0] rem_in;
  logic [2:0][QUO_W-1:0] nlo_in;

  logic ov_r;
  vec3_t quot_r, quot_nxt;
  carry_t ocarry_r;

  // top bits of the numerator are already below the divisor
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_in[l] = DEN_W'(in_num[l][NUM_W-1:QUO_W]);
      nlo_in[l] = in_num[l][QUO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[QUO_W-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    logic [2:0][DEN_W-1:0] rem_src, rem_nxt;
    logic [2:0][QUO_W-1:0] nlo_src, nlo_nxt, q_src, q_nxt;
    logic [2:0] neg_src;
    logic [DEN_W-1:0] den_src;
    carry_t carry_src;

    if (g == 0) begin : g_head
      assign rem_src   = rem_in;
      assign nlo_src   = nlo_in;
      assign q_src     = '0;
      assign neg_src   = in_neg;
      assign den_src   = in_den;
      assign carry_src = in_carry;
    end else begin : g_body
      assign rem_src   = rem_r[g-1];
      assign nlo_src   = nlo_r[g-1];
      assign q_src     = q_r[g-1];
      assign neg_src   = neg_r[g-1];
      assign den_src   = den_r[g-1];
      assign carry_src = carry_r[g-1];
    end

    // one quotient bit per stage, restoring
    always_comb begin
      logic [DEN_W:0] trial;
      for (int l = 0; l < 3; l++) begin
        trial = {rem_src[l], nlo_src[l][QUO_W-1]};
        nlo_nxt[l] = {nlo_src[l][QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, den_src}) begin
          rem_nxt[l] = DEN_W'(trial - {1'b0, den_src});
          q_nxt[l]   = {q_src[l][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = trial[DEN_W-1:0];
          q_nxt[l]   = {q_src[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g]   <= rem_nxt;
      nlo_r[g]   <= nlo_nxt;
      q_r[g]     <= q_nxt;
      neg_r[g]   <= neg_src;
      den_r[g]   <= den_src;
      carry_r[g] <= carry_src;
    end
  end

  // apply the sign and clamp
  always_comb begin
    logic [QUO_W-1:0] qf;
    for (int l = 0; l < 3; l++) begin
      qf = q_r[QUO_W-1][l];
      if (neg_r[QUO_W-1][l]) begin
        quot_nxt[l] = (qf > QNEG_MAX) ? WORD_MIN : word_t'(-qf);
      end else begin
        quot_nxt[l] = (qf > QPOS_MAX) ? WORD_MAX : qf[WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= v_r[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    quot_r   <= quot_nxt;
    ocarry_r <= carry_r[QUO_W-1];
  end

  assign out_valid = ov_r;
  assign out_quot  = quot_r;
  assign out_carry = ocarry_r;

  `BPP_ASSERT_IMP(a_rem_below_den, v_r[QUO_W-1], (rem_r[QUO_W-1][0] < den_r[QUO_W-1]) && (rem_r[QUO_W-1][1] < den_r[QUO_W-1]) && (rem_r[QUO_W-1][2] < den_r[QUO_W-1]))

endmodule

/* rtl/core/bpp_back.sv */
module bpp_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  bpp_pkg::vec3_t  in_quot,
  input  bpp_pkg::carry_t in_carry,
  input  logic [30:0]     time_step,
  output logic            out_valid,
  output bpp_pkg::vec3_t  out_pos,
  output bpp_pkg::vec3_t  out_vel
);
  import bpp_pkg::*;

  logic [BACK_STAGES:1] v_r;

  prod3_t pa1_r, pb1_r;
  vec3_t  u1_r, r1_r, pos1_r;
  vec3_t  w2_r, r2_r, pos2_r;
  vec3_t  vn3_r, pos3_r;
  prod3_t pt4_r;
  vec3_t  vn4_r, pos4_r;
  vec3_t  xn5_r, vn5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[BACK_STAGES-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pa1_r[i] <= smul(in_carry.vp[nx(i)], in_quot[pv(i)]);
      pb1_r[i] <= smul(in_carry.vp[pv(i)], in_quot[nx(i)]);
      w2_r[i]  <= sat_add(u1_r[i], sat_sub(fin(pa1_r[i], FRAC_BITS), fin(pb1_r[i], FRAC_BITS)));
      vn3_r[i] <= sat_add(w2_r[i], r2_r[i]);
      pt4_r[i] <= smul(vn3_r[i], {1'b0, time_step});
      xn5_r[i] <= sat_add(pos4_r[i], fin(pt4_r[i], FRAC_BITS));
    end
    u1_r   <= in_carry.u;
    r1_r   <= in_carry.r;
    pos1_r <= in_carry.pos;
    r2_r   <= r1_r;
    pos2_r <= pos1_r;
    pos3_r <= pos2_r;
    vn4_r  <= vn3_r;
    pos4_r <= pos3_r;
    vn5_r  <= vn4_r;
  end

  assign out_valid = v_r[BACK_STAGES];
  assign out_pos   = xn5_r;
  assign out_vel   = vn5_r;

endmodule

/* rtl/core/boris_particle_push_unit.sv */
// Boris particle pusher: one particle step per word.
// Input: raise start with the twelve in_ fields (position, velocity, local flow and
// magnetic field); the word is taken at the edge where start is high and busy is low.
// Output: out_valid strobes for one cycle with the new position and velocity; the
// receiver must take it then, as there is no way to hold results off.
// Config: cfg_valid/cfg_ready with cfg_index 0 (field scale k) or 1 (time step);
// cfg_ready is always high, other indexes are dropped. Write only while idle.
// From the accepting edge to the result strobe the pipeline has 7 front stages
// (cross products, |T|^2 and the divisor), 34 divider stages (one quotient bit per
// stage for the three S components, plus the sign stage) and 5 back stages.
// Throughput is one particle per cycle; the pipeline never stalls.
// Reset clears every valid bit, loads k = 0 and dt = 1.0, and holds busy high
// until the cycle after reset is released.
`include "boris_particle_push_unit_assert.svh"

module boris_particle_push_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              in_pos_x,
  input  logic signed [31:0]              in_pos_y,
  input  logic signed [31:0]              in_pos_z,
  input  logic signed [31:0]              in_vel_x,
  input  logic signed [31:0]              in_vel_y,
  input  logic signed [31:0]              in_vel_z,
  input  logic signed [31:0]              in_flow_x,
  input  logic signed [31:0]              in_flow_y,
  input  logic signed [31:0]              in_flow_z,
  input  logic signed [31:0]              in_mag_x,
  input  logic signed [31:0]              in_mag_y,
  input  logic signed [31:0]              in_mag_z,
  output logic                            out_valid,
  output logic signed [31:0]              out_new_pos_x,
  output logic signed [31:0]              out_new_pos_y,
  output logic signed [31:0]              out_new_pos_z,
  output logic signed [31:0]              out_new_vel_x,
  output logic signed [31:0]              out_new_vel_y,
  output logic signed [31:0]              out_new_vel_z,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import bpp_pkg::*;

  localparam int LATENCY = FRONT_STAGES + QUO_W + 1 + BACK_STAGES;

  logic busy_r;
  logic accept;
  word_t field_scale_r;
  logic [30:0] time_step_r;

  vec3_t in_pos, in_vel, in_flow, in_mag;

  logic fv;
  carry_t fcarry;
  logic [2:0][FRAC_BITS+QUO_W-1:0] fnum;
  logic [2:0] fneg;
  logic [DEN_W-1:0] fden;

  logic dv;
  vec3_t dquot;
  carry_t dcarry;

  vec3_t new_pos, new_vel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign accept    = start && !busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_scale_r <= '0;
      time_step_r   <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIELD_SCALE: begin
          field_scale_r <= cfg_data;
        end
        REG_TIME_STEP: begin
          time_step_r <= cfg_data[30:0];
        end
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  assign in_pos  = {in_pos_z, in_pos_y, in_pos_x};
  assign in_vel  = {in_vel_z, in_vel_y, in_vel_x};
  assign in_flow = {in_flow_z, in_flow_y, in_flow_x};
  assign in_mag  = {in_mag_z, in_mag_y, in_mag_x};

  bpp_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .in_pos     (in_pos),
    .in_vel     (in_vel),
    .in_flow    (in_flow),
    .in_mag     (in_mag),
    .field_scale(field_scale_r),
    .out_valid  (fv),
    .out_carry  (fcarry),
    .out_num    (fnum),
    .out_neg    (fneg),
    .out_den    (fden)
  );

  bpp_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (fv),
    .in_carry (fcarry),
    .in_num   (fnum),
    .in_neg   (fneg),
    .in_den   (fden),
    .out_valid(dv),
    .out_quot (dquot),
    .out_carry(dcarry)
  );

  bpp_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dv),
    .in_quot  (dquot),
    .in_carry (dcarry),
    .time_step(time_step_r),
    .out_valid(out_valid),
    .out_pos  (new_pos),
    .out_vel  (new_vel)
  );

  assign out_new_pos_x = new_pos[0];
  assign out_new_pos_y = new_pos[1];
  assign out_new_pos_z = new_pos[2];
  assign out_new_vel_x = new_vel[0];
  assign out_new_vel_y = new_vel[1];
  assign out_new_vel_z = new_vel[2];

  `BPP_ASSERT_IMP(a_latency, out_valid, $past(accept, LATENCY))
  `BPP_ASSERT_NEXT(a_ts_write, cfg_valid && cfg_ready && (cfg_index == REG_TIME_STEP), time_step_r == $past(cfg_data[30:0]))

endmodule
